FILE: rtl/core/mdb_pkg.sv
// Shared types, codes and defaults for the market depth book.
package mdb_pkg;

  localparam int unsigned MaxRowsDefault   = 64;
  localparam int unsigned MaxLevelsDefault = 64;

  typedef enum logic [1:0] {
    CMD_ADD    = 2'd0,
    CMD_UPDATE = 2'd1,
    CMD_REMOVE = 2'd2,
    CMD_QUERY  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    ST_OK     = 2'd0,
    ST_BADPOS = 2'd1,
    ST_FULL   = 2'd2
  } status_t;

  typedef enum logic [12:0] {
    S_IDLE   = 13'b0000000000001,
    S_DISP   = 13'b0000000000010,
    S_QRY    = 13'b0000000000100,
    S_ROWRD  = 13'b0000000001000,
    S_SCAN   = 13'b0000000010000,
    S_LVCHK  = 13'b0000000100000,
    S_COMMIT = 13'b0000001000000,
    S_RSH    = 13'b0000010000000,
    S_RWR    = 13'b0000100000000,
    S_LVUPD  = 13'b0001000000000,
    S_LSH    = 13'b0010000000000,
    S_LWR    = 13'b0100000000000,
    S_DONE   = 13'b1000000000000
  } state_t;

  typedef struct packed {
    cmd_t        command;
    logic        side;
    logic [5:0]  position;
    logic [31:0] price_ticks;
    logic [31:0] quantity;
    logic [5:0]  level_depth;
  } item_t;

  typedef struct packed {
    logic [31:0] level_price;
    logic [31:0] level_size;
    status_t     status;
  } result_t;

endpackage

FILE: rtl/core/mdb_ram.sv
// Simple dual-port synchronous memory with registered read data.
module mdb_ram #(
  parameter int unsigned AW = 7,
  parameter int unsigned DW = 64
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [DW-1:0] wdata,
  input  logic [AW-1:0] raddr,
  output logic [DW-1:0] rdata
);

  logic [DW-1:0] mem [2**AW];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/core/mdb_seq.sv
// Sequencer: row and level memories, level search, shifts and total update.
module mdb_seq #(
  parameter int unsigned MAX_ROWS   = mdb_pkg::MaxRowsDefault,
  parameter int unsigned MAX_LEVELS = mdb_pkg::MaxLevelsDefault
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  mdb_pkg::item_t   item_in,
  output logic             idle,
  output logic             done,
  input  logic             res_take,
  output mdb_pkg::result_t res
);

  localparam int unsigned RW  = $clog2(MAX_ROWS);
  localparam int unsigned RCW = $clog2(MAX_ROWS + 1);
  localparam int unsigned LW  = $clog2(MAX_LEVELS);
  localparam int unsigned LCW = $clog2(MAX_LEVELS + 1);

  mdb_pkg::state_t  state, state_next;
  mdb_pkg::item_t   it;
  mdb_pkg::result_t res_next;

  logic [RCW-1:0] rcnt [2];
  logic [LCW-1:0] lcnt [2];
  logic [RW-1:0]  ri, ri_next, rat, rat_next;
  logic [LW-1:0]  li, li_next, lj, lj_next;
  logic           found, found_next;
  logic [31:0]    oldtot, oldtot_next, oldsize, oldsize_next;
  logic [31:0]    oldprice, oldprice_next, lprice, lprice_next;
  logic           rinc, rdec, linc;

  logic           row_we, lv_we;
  logic [RW:0]    row_waddr, row_raddr;
  logic [LW:0]    lv_waddr, lv_raddr;
  logic [63:0]    row_wdata, row_rdata, lv_wdata, lv_rdata;

  logic [RCW-1:0] cur_rcnt;
  logic [LCW-1:0] cur_lcnt;
  logic [RW-1:0]  at;
  logic signed [33:0] delta, tsum;
  logic [31:0]    base, newtot;

  assign cur_rcnt = rcnt[it.side];
  assign cur_lcnt = lcnt[it.side];
  assign idle     = (state == mdb_pkg::S_IDLE);
  assign done     = (state == mdb_pkg::S_DONE);

  always_comb begin
    unique case (it.command)
      mdb_pkg::CMD_ADD:    delta = $signed({2'b00, it.quantity});
      mdb_pkg::CMD_UPDATE: delta = $signed({2'b00, it.quantity}) - $signed({2'b00, oldsize});
      default:             delta = -$signed({2'b00, oldsize});
    endcase
    base = found ? oldtot : 32'd0;
    tsum = $signed({2'b00, base}) + delta;
    if (tsum[33]) begin
      newtot = 32'd0;
    end else if (tsum[32]) begin
      newtot = 32'hFFFF_FFFF;
    end else begin
      newtot = tsum[31:0];
    end
    at = (int'(it.position) < int'(cur_rcnt)) ? RW'(it.position) : RW'(cur_rcnt);
  end

  always_comb begin
    state_next    = state;
    res_next      = res;
    ri_next       = ri;
    rat_next      = rat;
    li_next       = li;
    lj_next       = lj;
    found_next    = found;
    oldtot_next   = oldtot;
    oldsize_next  = oldsize;
    oldprice_next = oldprice;
    lprice_next   = lprice;
    rinc          = 1'b0;
    rdec          = 1'b0;
    linc          = 1'b0;
    row_we        = 1'b0;
    row_waddr     = {it.side, ri};
    row_wdata     = row_rdata;
    row_raddr     = {it.side, ri};
    lv_we         = 1'b0;
    lv_waddr      = {it.side, li};
    lv_wdata      = {lprice, newtot};
    lv_raddr      = {it.side, li};
    unique case (state)
      mdb_pkg::S_IDLE: begin
        if (start) state_next = mdb_pkg::S_DISP;
      end
      mdb_pkg::S_DISP: begin
        res_next.level_price = 32'd0;
        res_next.level_size  = 32'd0;
        res_next.status      = mdb_pkg::ST_OK;
        unique case (it.command)
          mdb_pkg::CMD_QUERY: begin
            if (int'(it.level_depth) < int'(cur_lcnt)) begin
              lv_raddr   = {it.side, LW'(it.level_depth)};
              state_next = mdb_pkg::S_QRY;
            end else begin
              state_next = mdb_pkg::S_DONE;
            end
          end
          mdb_pkg::CMD_ADD: begin
            if (int'(cur_rcnt) >= int'(MAX_ROWS)) begin
              res_next.status = mdb_pkg::ST_BADPOS;
              state_next      = mdb_pkg::S_DONE;
            end else begin
              lprice_next = it.price_ticks;
              state_next  = mdb_pkg::S_SCAN;
            end
          end
          default: begin
            if (int'(it.position) >= int'(cur_rcnt)) begin
              res_next.status = mdb_pkg::ST_BADPOS;
              state_next      = mdb_pkg::S_DONE;
            end else begin
              row_raddr  = {it.side, RW'(it.position)};
              state_next = mdb_pkg::S_ROWRD;
            end
          end
        endcase
      end
      mdb_pkg::S_QRY: begin
        res_next.level_price = lv_rdata[63:32];
        res_next.level_size  = lv_rdata[31:0];
        state_next           = mdb_pkg::S_DONE;
      end
      mdb_pkg::S_ROWRD: begin
        oldsize_next  = row_rdata[31:0];
        oldprice_next = row_rdata[63:32];
        lprice_next   = (it.command == mdb_pkg::CMD_REMOVE) ? row_rdata[63:32]
                                                            : it.price_ticks;
        state_next    = mdb_pkg::S_SCAN;
      end
      mdb_pkg::S_SCAN: begin
        li_next    = '0;
        found_next = 1'b0;
        lv_raddr   = {it.side, LW'(0)};
        state_next = (cur_lcnt == '0) ? mdb_pkg::S_COMMIT : mdb_pkg::S_LVCHK;
      end
      mdb_pkg::S_LVCHK: begin
        if (lv_rdata[63:32] == lprice) begin
          found_next  = 1'b1;
          oldtot_next = lv_rdata[31:0];
          state_next  = mdb_pkg::S_COMMIT;
        end else if (it.side ? (lv_rdata[63:32] > lprice)
                             : (lv_rdata[63:32] < lprice)) begin
          state_next = mdb_pkg::S_COMMIT;
        end else begin
          li_next = li + LW'(1);
          if (LCW'(li) + LCW'(1) == cur_lcnt) begin
            state_next = mdb_pkg::S_COMMIT;
          end else begin
            lv_raddr = {it.side, li + LW'(1)};
          end
        end
      end
      mdb_pkg::S_COMMIT: begin
        if (!found && int'(cur_lcnt) >= int'(MAX_LEVELS)) begin
          res_next.status = mdb_pkg::ST_FULL;
          state_next      = mdb_pkg::S_DONE;
        end else begin
          unique case (it.command)
            mdb_pkg::CMD_ADD: begin
              rat_next = at;
              ri_next  = RW'(cur_rcnt);
              if (RW'(cur_rcnt) == at) begin
                state_next = mdb_pkg::S_RWR;
              end else begin
                row_raddr  = {it.side, RW'(cur_rcnt) - RW'(1)};
                state_next = mdb_pkg::S_RSH;
              end
            end
            mdb_pkg::CMD_UPDATE: begin
              row_we     = 1'b1;
              row_waddr  = {it.side, RW'(it.position)};
              row_wdata  = {oldprice, it.quantity};
              state_next = mdb_pkg::S_LVUPD;
            end
            default: begin
              ri_next = RW'(it.position);
              if (RCW'(it.position) + RCW'(1) == cur_rcnt) begin
                rdec       = 1'b1;
                state_next = mdb_pkg::S_LVUPD;
              end else begin
                row_raddr  = {it.side, RW'(it.position) + RW'(1)};
                state_next = mdb_pkg::S_RSH;
              end
            end
          endcase
        end
      end
      mdb_pkg::S_RSH: begin
        // move one row per cycle towards the gap
        row_we = 1'b1;
        if (it.command == mdb_pkg::CMD_ADD) begin
          ri_next = ri - RW'(1);
          if (ri - RW'(1) == rat) begin
            state_next = mdb_pkg::S_RWR;
          end else begin
            row_raddr = {it.side, ri - RW'(2)};
          end
        end else begin
          ri_next = ri + RW'(1);
          if (RCW'(ri) + RCW'(2) == cur_rcnt) begin
            rdec       = 1'b1;
            state_next = mdb_pkg::S_LVUPD;
          end else begin
            row_raddr = {it.side, ri + RW'(2)};
          end
        end
      end
      mdb_pkg::S_RWR: begin
        row_we     = 1'b1;
        row_waddr  = {it.side, rat};
        row_wdata  = {it.price_ticks, it.quantity};
        rinc       = 1'b1;
        state_next = mdb_pkg::S_LVUPD;
      end
      mdb_pkg::S_LVUPD: begin
        if (found) begin
          lv_we      = 1'b1;
          state_next = mdb_pkg::S_DONE;
        end else if (LCW'(li) == cur_lcnt) begin
          lv_we      = 1'b1;
          linc       = 1'b1;
          state_next = mdb_pkg::S_DONE;
        end else begin
          lj_next    = LW'(cur_lcnt);
          lv_raddr   = {it.side, LW'(cur_lcnt) - LW'(1)};
          state_next = mdb_pkg::S_LSH;
        end
      end
      mdb_pkg::S_LSH: begin
        lv_we    = 1'b1;
        lv_waddr = {it.side, lj};
        lv_wdata = lv_rdata;
        lj_next  = lj - LW'(1);
        if (lj - LW'(1) == li) begin
          state_next = mdb_pkg::S_LWR;
        end else begin
          lv_raddr = {it.side, lj - LW'(2)};
        end
      end
      mdb_pkg::S_LWR: begin
        lv_we      = 1'b1;
        linc       = 1'b1;
        state_next = mdb_pkg::S_DONE;
      end
      mdb_pkg::S_DONE: begin
        if (res_take) state_next = mdb_pkg::S_IDLE;
      end
      default: state_next = mdb_pkg::S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= mdb_pkg::S_IDLE;
      rcnt  <= '{default: '0};
      lcnt  <= '{default: '0};
    end else begin
      state <= state_next;
      if (rinc) rcnt[it.side] <= cur_rcnt + RCW'(1);
      if (rdec) rcnt[it.side] <= cur_rcnt - RCW'(1);
      if (linc) lcnt[it.side] <= cur_lcnt + LCW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (start && idle) it <= item_in;
    res      <= res_next;
    ri       <= ri_next;
    rat      <= rat_next;
    li       <= li_next;
    lj       <= lj_next;
    found    <= found_next;
    oldtot   <= oldtot_next;
    oldsize  <= oldsize_next;
    oldprice <= oldprice_next;
    lprice   <= lprice_next;
  end

  mdb_ram #(.AW(RW + 1), .DW(64)) u_rows (
    .clk  (clk),
    .we   (row_we),
    .waddr(row_waddr),
    .wdata(row_wdata),
    .raddr(row_raddr),
    .rdata(row_rdata)
  );

  mdb_ram #(.AW(LW + 1), .DW(64)) u_levels (
    .clk  (clk),
    .we   (lv_we),
    .waddr(lv_waddr),
    .wdata(lv_wdata),
    .raddr(lv_raddr),
    .rdata(lv_rdata)
  );

endmodule

FILE: rtl/core/market_depth_book_top.sv
// Top level of the market depth book: stream ports, output register, sequencer.
//
//  channel   direction  carries
//  s_*       in         command item (add, update, remove, query)
//  m_*       out        result item (level price, level size, status)
//
// Add, update and remove scan the levels (one level per cycle through the level
// memory read port), then move the rows or levels that open or close a gap
// (one entry per cycle, read and write ports working together). A query reads
// a single level from the level memory.
// One item is in work at a time.
// Reset clears the row and level counts; memory contents need no clearing.
// A result waiting in the output register holds the sequencer at its end,
// while s_tready stays high whenever the sequencer is idle.
module market_depth_book_top #(
  parameter int unsigned MAX_ROWS   = mdb_pkg::MaxRowsDefault,
  parameter int unsigned MAX_LEVELS = mdb_pkg::MaxLevelsDefault
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [79:0] s_tdata,  // position[5:0], price_ticks[37:6], quantity[69:38],
                                // level_depth[75:70], zero pad[79:76]
  input  logic [2:0]  s_tuser,  // command[1:0], side[2]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,  // level_price[31:0], level_size[63:32]
  output logic [1:0]  m_tuser   // status[1:0]
);

  mdb_pkg::item_t   item;
  mdb_pkg::result_t res;
  logic             seq_idle, seq_done, res_take, accept;

  // unpack the incoming item
  assign item.command     = mdb_pkg::cmd_t'(s_tuser[1:0]);
  assign item.side        = s_tuser[2];
  assign item.position    = s_tdata[5:0];
  assign item.price_ticks = s_tdata[37:6];
  assign item.quantity    = s_tdata[69:38];
  assign item.level_depth = s_tdata[75:70];

  assign s_tready = seq_idle;
  assign accept   = s_tvalid && s_tready;

  // load the output register once it is free or being emptied
  assign res_take = seq_done && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (res_take) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (res_take) begin
      m_tdata <= {res.level_size, res.level_price};
      m_tuser <= res.status;
    end
  end

  mdb_seq #(.MAX_ROWS(MAX_ROWS), .MAX_LEVELS(MAX_LEVELS)) u_seq (
    .clk     (clk),
    .rst     (rst),
    .start   (accept),
    .item_in (item),
    .idle    (seq_idle),
    .done    (seq_done),
    .res_take(res_take),
    .res     (res)
  );

  // an accepted item occupies the sequencer in the next cycle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (rst)
    accept |=> !s_tready)
    else $error("sequencer idle right after accepting an item");

  // a new result only appears after the sequencer hands one over
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(res_take))
    else $error("result raised without a finished item");

  // the sequencer never finishes while idle
  a_done_not_idle: assert property (@(posedge clk) disable iff (rst)
    !(seq_done && seq_idle))
    else $error("sequencer both idle and done");

endmodule
